/* rtl/sitda_pkg.sv */
// Shared types and constants for the signed integer to decimal ASCII converter.
package sitda_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int CHAR_WIDTH  = 7;
   localparam int DIGIT_WIDTH = 4;
   localparam int QUOT_WIDTH  = 29;
   localparam int PROD_WIDTH  = 64;
   localparam int RECIP_SHIFT = 35;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [VALUE_WIDTH-1:0] RECIP_TEN  = 32'hCCCC_CCCD;
   localparam logic [DIGIT_WIDTH-1:0] MAX_DIGITS = 4'd10;
   localparam logic [CHAR_WIDTH-1:0]  CHAR_MINUS = 7'd45;
   localparam logic [CHAR_WIDTH-1:0]  CHAR_ZERO  = 7'd48;

   typedef struct packed {
      logic                   negative;
      logic [VALUE_WIDTH-1:0] magnitude;
   } job_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SIGN,
      ST_DIGITS
   } state_type;

endpackage

/* rtl/sitda_front.sv */
// Input side: sign and magnitude split and a two-entry word queue toward the converter.
module sitda_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic signed [sitda_pkg::VALUE_WIDTH-1:0] req_value,
   output logic                                job_valid,
   input  logic                                job_ready,
   output sitda_pkg::job_type                  job
);

   sitda_pkg::job_type entries_ff [sitda_pkg::QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push_ok;
   logic       pop_ok;
   sitda_pkg::job_type classified;

   always_comb begin
      classified.negative  = req_value[sitda_pkg::VALUE_WIDTH-1];
      classified.magnitude = classified.negative ? (32'd0 - req_value) : req_value;
   end

   assign req_full  = (count_ff == 2'(sitda_pkg::QUEUE_DEPTH));
   assign job_valid = (count_ff != 2'd0);
   assign job       = entries_ff[rd_ptr_ff];
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = job_valid && job_ready;

   always_comb begin
      wr_ptr_in = push_ok ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_ok ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push_ok) - 2'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         entries_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

/* rtl/sitda_back.sv */
// Converter: digit extraction by reciprocal multiply and character output register.
module sitda_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  job_valid,
   output logic                                  job_ready,
   input  sitda_pkg::job_type                    job,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic [sitda_pkg::CHAR_WIDTH-1:0]      rsp_character,
   output logic                                  rsp_last
);

   sitda_pkg::state_type state_ff, state_in;

   logic [sitda_pkg::QUOT_WIDTH-1:0]  q_ff, q_in;
   logic [sitda_pkg::DIGIT_WIDTH-1:0] mag_lo_ff, mag_lo_in;
   logic                              neg_ff, neg_in;
   logic [sitda_pkg::DIGIT_WIDTH-1:0] ndig_ff, ndig_in;
   logic [sitda_pkg::DIGIT_WIDTH-1:0] idx_ff, idx_in;
   logic [sitda_pkg::DIGIT_WIDTH-1:0] rev_ff [10];
   logic                              rev_we;
   logic [sitda_pkg::DIGIT_WIDTH-1:0] digit;

   logic                              out_valid_ff, out_valid_in;
   logic [sitda_pkg::CHAR_WIDTH-1:0]  char_ff, char_in;
   logic                              last_ff, last_in;

   logic [sitda_pkg::VALUE_WIDTH-1:0] mult_a;
   logic [sitda_pkg::PROD_WIDTH-1:0]  product;
   logic [sitda_pkg::DIGIT_WIDTH-1:0] q_times_ten_lo;
   logic [sitda_pkg::DIGIT_WIDTH-1:0] ndig_next;
   logic                              out_load;
   logic                              pop_ok;

   assign pop_ok   = rsp_pop && out_valid_ff;
   assign out_load = !out_valid_ff || rsp_pop;

   assign mult_a  = (state_ff == sitda_pkg::ST_IDLE) ? job.magnitude
                                                      : {3'b000, q_ff};
   assign product = 64'(mult_a) * 64'(sitda_pkg::RECIP_TEN);

   assign q_times_ten_lo = 4'({q_ff[0], 3'b000}) + 4'({q_ff[2:0], 1'b0});
   assign digit          = mag_lo_ff - q_times_ten_lo;
   assign ndig_next      = ndig_ff + 4'd1;

   always_comb begin
      state_in     = state_ff;
      job_ready    = 1'b0;
      q_in         = q_ff;
      mag_lo_in    = mag_lo_ff;
      neg_in       = neg_ff;
      ndig_in      = ndig_ff;
      idx_in       = idx_ff;
      rev_we       = 1'b0;
      out_valid_in = out_valid_ff && !pop_ok;
      char_in      = char_ff;
      last_in      = last_ff;
      case (state_ff)
         sitda_pkg::ST_IDLE: begin
            job_ready = 1'b1;
            if (job_valid) begin
               q_in      = product[sitda_pkg::PROD_WIDTH-1:sitda_pkg::RECIP_SHIFT];
               mag_lo_in = job.magnitude[sitda_pkg::DIGIT_WIDTH-1:0];
               neg_in    = job.negative;
               ndig_in   = 4'd0;
               state_in  = sitda_pkg::ST_CONVERT;
            end
         end
         sitda_pkg::ST_CONVERT: begin
            rev_we    = 1'b1;
            ndig_in   = ndig_next;
            mag_lo_in = q_ff[sitda_pkg::DIGIT_WIDTH-1:0];
            q_in      = product[sitda_pkg::PROD_WIDTH-1:sitda_pkg::RECIP_SHIFT];
            if ((q_ff == '0) || (ndig_next == sitda_pkg::MAX_DIGITS)) begin
               idx_in   = ndig_ff;
               state_in = neg_ff ? sitda_pkg::ST_SIGN : sitda_pkg::ST_DIGITS;
            end
         end
         sitda_pkg::ST_SIGN: begin
            if (out_load) begin
               out_valid_in = 1'b1;
               char_in      = sitda_pkg::CHAR_MINUS;
               last_in      = 1'b0;
               state_in     = sitda_pkg::ST_DIGITS;
            end
         end
         sitda_pkg::ST_DIGITS: begin
            if (out_load) begin
               out_valid_in = 1'b1;
               char_in      = sitda_pkg::CHAR_ZERO + {3'b000, rev_ff[idx_ff]};
               last_in      = (idx_ff == 4'd0);
               idx_in       = idx_ff - 4'd1;
               if (idx_ff == 4'd0) begin
                  state_in = sitda_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = sitda_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sitda_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff      <= q_in;
      mag_lo_ff <= mag_lo_in;
      neg_ff    <= neg_in;
      ndig_ff   <= ndig_in;
      idx_ff    <= idx_in;
      char_ff   <= char_in;
      last_ff   <= last_in;
      if (rev_we) begin
         rev_ff[ndig_ff] <= digit;
      end
   end

   assign rsp_empty     = !out_valid_ff;
   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;

endmodule

/* rtl/signed_int_to_decimal_ascii.sv */
// Top level of the signed 32-bit integer to decimal ASCII converter.
// Each word pushed is a signed 32-bit integer; the block pops out its decimal text one
// character per word, most significant first, with a leading '-' for negative values and
// rsp_last set on the final character. A two-entry input queue takes words while the
// converter is busy. The converter loads a word, then extracts one digit at a time
// through a single 32x32 reciprocal multiply by 1/10 into a registered quotient, then
// passes each character through the output register; it takes no new word until the
// last character of the current one has been loaded into the output register.
module signed_int_to_decimal_ascii (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_push,
   output logic                                      req_full,
   input  logic signed [sitda_pkg::VALUE_WIDTH-1:0]  req_value,
   output logic                                      rsp_empty,
   input  logic                                      rsp_pop,
   output logic [sitda_pkg::CHAR_WIDTH-1:0]          rsp_character,
   output logic                                      rsp_last
);

   logic               job_valid;
   logic               job_ready;
   sitda_pkg::job_type job;

   sitda_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_value (req_value),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job       (job)
   );

   sitda_back u_back (
      .clock         (clock),
      .reset         (reset),
      .job_valid     (job_valid),
      .job_ready     (job_ready),
      .job           (job),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule

/* rtl/sitda_checker.sv */
// Port-level checks for the decimal ASCII converter and their binding to the top level.
module sitda_checker (
   input logic                                      clock,
   input logic                                      reset,
   input logic                                      req_push,
   input logic                                      req_full,
   input logic signed [sitda_pkg::VALUE_WIDTH-1:0]  req_value,
   input logic                                      rsp_empty,
   input logic                                      rsp_pop,
   input logic [sitda_pkg::CHAR_WIDTH-1:0]          rsp_character,
   input logic                                      rsp_last
);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   a_hold_word: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_character) && $stable(rsp_last))
      else $error("waiting word changed");

   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_character == sitda_pkg::CHAR_MINUS && !rsp_last) ||
                     (rsp_character >= sitda_pkg::CHAR_ZERO &&
                      rsp_character <= sitda_pkg::CHAR_ZERO + 7'd9))
      else $error("illegal character word");

   a_minus_then_digit: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_pop && rsp_character == sitda_pkg::CHAR_MINUS
         |=> rsp_empty || rsp_character != sitda_pkg::CHAR_MINUS)
      else $error("sign not followed by digit");

endmodule

bind signed_int_to_decimal_ascii sitda_checker u_checker (.*);

/* tb/signed_int_to_decimal_ascii_tb.sv */
// Testbench for the signed 32-bit integer to decimal ASCII converter.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_tb;

   typedef struct packed {
      logic [sitda_pkg::CHAR_WIDTH-1:0] character;
      logic                             last;
   } text_char_type;

   logic                                     clock;
   logic                                     reset;
   logic                                     req_push;
   logic                                     req_full;
   logic signed [sitda_pkg::VALUE_WIDTH-1:0] req_value;
   logic                                     rsp_empty;
   logic                                     rsp_pop;
   logic [sitda_pkg::CHAR_WIDTH-1:0]         rsp_character;
   logic                                     rsp_last;

   logic [sitda_pkg::VALUE_WIDTH-1:0] pending_values[$];
   text_char_type                     expected_text[$];
   int                                error_count = 0;
   bit                                req_taken = 0;
   bit                                rsp_taken = 0;
   bit                                tx_steady = 0;
   bit                                rx_steady = 0;
   int                                tx_gap = 0;
   int                                rx_gap = 0;
   int                                rx_hold = 0;
   int                                long_stall_count = 0;
   int                                long_stall_seen = 0;

   signed_int_to_decimal_ascii dut (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_value     (req_value),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void queue_decimal_text(
      input logic [sitda_pkg::VALUE_WIDTH-1:0] word);
      logic                              negative;
      logic [sitda_pkg::VALUE_WIDTH-1:0] magnitude;
      logic [sitda_pkg::DIGIT_WIDTH-1:0] digits [10];
      int                                count;
      text_char_type                     entry;
      negative  = word[sitda_pkg::VALUE_WIDTH-1];
      magnitude = negative ? -word : word;
      count     = 0;
      do begin
         digits[count] = sitda_pkg::DIGIT_WIDTH'(magnitude % 10);
         count++;
         magnitude = magnitude / 10;
      end while (magnitude != 0 && count < 10);
      if (negative) begin
         entry.character = sitda_pkg::CHAR_MINUS;
         entry.last      = 1'b0;
         expected_text.push_back(entry);
      end
      for (int i = count - 1; i >= 0; i--) begin
         entry.character = sitda_pkg::CHAR_ZERO + sitda_pkg::CHAR_WIDTH'(digits[i]);
         entry.last      = (i == 0);
         expected_text.push_back(entry);
      end
   endfunction

   function automatic logic [sitda_pkg::VALUE_WIDTH-1:0] draw_value();
      int unsigned lo;
      int unsigned hi;
      int unsigned magnitude;
      int          digit_count;
      if ($urandom_range(0, 3) == 0) begin
         return $urandom();
      end
      digit_count = $urandom_range(1, 10);
      lo = 1;
      repeat (digit_count - 1) lo = lo * 10;
      hi = (digit_count == 10) ? 32'h7FFF_FFFF : lo * 10 - 1;
      magnitude = $urandom_range(hi, lo);
      return $urandom_range(0, 1) ? -magnitude : magnitude;
   endfunction

   task automatic wait_for_drain();
      while (pending_values.size() != 0 || req_push || expected_text.size() != 0) begin
         @(posedge clock);
      end
   endtask

   always @(posedge clock) begin : monitor
      text_char_type want;
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
      end else begin
         req_taken <= req_push && !req_full;
         rsp_taken <= rsp_pop && !rsp_empty;
         if (req_push && !req_full) begin
            queue_decimal_text(req_value);
         end
         if (rsp_pop && !rsp_empty) begin
            if (expected_text.size() == 0) begin
               error_count++;
               $display("%0t: unexpected word: expected none, actual character %0d last %0b",
                        $time, rsp_character, rsp_last);
            end else begin
               want = expected_text.pop_front();
               if (rsp_character !== want.character) begin
                  error_count++;
                  $display("%0t: character mismatch: expected %0d, actual %0d",
                           $time, want.character, rsp_character);
               end
               if (rsp_last !== want.last) begin
                  error_count++;
                  $display("%0t: last mismatch: expected %0b, actual %0b",
                           $time, want.last, rsp_last);
               end
            end
         end
      end
   end

   always @(negedge clock) begin : driver
      logic                              next_push;
      logic [sitda_pkg::VALUE_WIDTH-1:0] next_value;
      next_push  = req_push;
      next_value = req_value;
      if (reset) begin
         next_push = 1'b0;
      end else if (!req_push || req_taken) begin
         next_push = 1'b0;
         if (tx_gap > 0) begin
            tx_gap--;
         end else if (pending_values.size() != 0) begin
            next_push  = 1'b1;
            next_value = pending_values.pop_front();
            tx_gap     = tx_steady ? 0 : $urandom_range(0, 11);
         end
      end
      req_push  <= next_push;
      req_value <= next_value;
   end

   always @(negedge clock) begin : receiver
      logic next_pop;
      next_pop = 1'b0;
      if (!reset) begin
         if (rx_hold > 0) begin
            rx_hold--;
         end else if (long_stall_seen != long_stall_count) begin
            long_stall_seen = long_stall_count;
            rx_hold         = 300;
         end else begin
            if (rsp_taken) begin
               rx_gap = rx_steady ? 0 : $urandom_range(0, 11);
            end
            if (rx_gap > 0) begin
               rx_gap--;
            end else begin
               next_pop = 1'b1;
            end
         end
      end
      rsp_pop <= next_pop;
   end

   initial begin
      #3_000_000;
      $display("signed_int_to_decimal_ascii verification failed");
      $finish;
   end

   initial begin : stimulus
      int corner_values [22];
      corner_values = '{
         0, 1, -1, 9, -9, 10, -10, 99, -100, 12345, -98765,
         1000000000, -1000000000, 999999999, -999999999,
         2147483647, -2147483647, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
         1234567890, 32'h0F0F_0F0F
      };
      reset     = 1'b1;
      req_push  = 1'b0;
      req_value = '0;
      rsp_pop   = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (corner_values[i]) pending_values.push_back(corner_values[i]);
      wait_for_drain();

      // hold the receiver back while words keep coming, so the input side stalls
      tx_steady = 1'b1;
      long_stall_count++;
      repeat (30) pending_values.push_back(draw_value());
      wait_for_drain();
      tx_steady = 1'b0;

      for (int phase = 0; phase < 4; phase++) begin
         tx_steady = (phase == 1);
         rx_steady = (phase == 2) || (phase == 1);
         repeat (25) pending_values.push_back(draw_value());
         wait_for_drain();
      end

      repeat (40) @(posedge clock);
      if (error_count == 0 && expected_text.size() == 0) begin
         $display("signed_int_to_decimal_ascii verification clean");
      end else begin
         $display("signed_int_to_decimal_ascii verification failed");
      end
      $finish;
   end

endmodule
